// ===== hdl/mps_pkg.sv =====
// types, constants and helpers shared by the modem power sequencer
`default_nettype none
package mps_pkg;

   localparam int CFG_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int CMD_WIDTH           = 2;
   localparam int BEEP_WIDTH          = 3;
   localparam int PHASE_WIDTH         = 4;

   localparam logic [CFG_WIDTH-1:0] DEFAULT_TICKS = CFG_WIDTH'(3000);

   // register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_PULSE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SETTLE     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RELAY_HOLD = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COOLDOWN   = 2'd3;

   // command codes
   localparam logic [CMD_WIDTH-1:0] CMD_NONE    = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_RESTART = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_RELEASE = 2'd2;

   // buzzer codes
   localparam logic [BEEP_WIDTH-1:0] BEEP_NONE     = 3'd0;
   localparam logic [BEEP_WIDTH-1:0] BEEP_START    = 3'd2;
   localparam logic [BEEP_WIDTH-1:0] BEEP_OFF_FAIL = 3'd3;
   localparam logic [BEEP_WIDTH-1:0] BEEP_ON_FAIL  = 3'd4;

   // reported phase numbers
   localparam logic [PHASE_WIDTH-1:0] PNUM_IDLE       = 4'd0;
   localparam logic [PHASE_WIDTH-1:0] PNUM_OFF        = 4'd1;
   localparam logic [PHASE_WIDTH-1:0] PNUM_OFF_HOLD   = 4'd2;
   localparam logic [PHASE_WIDTH-1:0] PNUM_OFF_SETTLE = 4'd3;
   localparam logic [PHASE_WIDTH-1:0] PNUM_ON         = 4'd4;
   localparam logic [PHASE_WIDTH-1:0] PNUM_ON_HOLD    = 4'd5;
   localparam logic [PHASE_WIDTH-1:0] PNUM_ON_SETTLE  = 4'd6;
   localparam logic [PHASE_WIDTH-1:0] PNUM_HARD       = 4'd7;
   localparam logic [PHASE_WIDTH-1:0] PNUM_HARD_HOLD  = 4'd8;
   localparam logic [PHASE_WIDTH-1:0] PNUM_COOLDOWN   = 4'd9;
   localparam logic [PHASE_WIDTH-1:0] PNUM_DONE       = 4'd10;

   typedef enum logic [10:0] {
      PH_IDLE       = 11'b000_0000_0001,
      PH_OFF        = 11'b000_0000_0010,
      PH_OFF_HOLD   = 11'b000_0000_0100,
      PH_OFF_SETTLE = 11'b000_0000_1000,
      PH_ON         = 11'b000_0001_0000,
      PH_ON_HOLD    = 11'b000_0010_0000,
      PH_ON_SETTLE  = 11'b000_0100_0000,
      PH_HARD       = 11'b000_1000_0000,
      PH_HARD_HOLD  = 11'b001_0000_0000,
      PH_COOLDOWN   = 11'b010_0000_0000,
      PH_DONE       = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] key_pulse_ticks;
      logic [CFG_WIDTH-1:0] settle_ticks;
      logic [CFG_WIDTH-1:0] relay_hold_ticks;
      logic [CFG_WIDTH-1:0] cooldown_ticks;
   } cfg_type;

   typedef struct packed {
      logic                   power_key;
      logic                   relay_energised;
      logic                   complete;
      logic                   accepted;
      logic [BEEP_WIDTH-1:0]  beep_pulses;
      logic [PHASE_WIDTH-1:0] phase;
   } result_type;

   function automatic logic [PHASE_WIDTH-1:0] phase_number(input phase_type ph);
      logic [PHASE_WIDTH-1:0] num;
      unique case (ph)
         PH_IDLE:       num = PNUM_IDLE;
         PH_OFF:        num = PNUM_OFF;
         PH_OFF_HOLD:   num = PNUM_OFF_HOLD;
         PH_OFF_SETTLE: num = PNUM_OFF_SETTLE;
         PH_ON:         num = PNUM_ON;
         PH_ON_HOLD:    num = PNUM_ON_HOLD;
         PH_ON_SETTLE:  num = PNUM_ON_SETTLE;
         PH_HARD:       num = PNUM_HARD;
         PH_HARD_HOLD:  num = PNUM_HARD_HOLD;
         PH_COOLDOWN:   num = PNUM_COOLDOWN;
         PH_DONE:       num = PNUM_DONE;
         default:       num = PNUM_IDLE;
      endcase
      return num;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/modem_power_sequencer_top.sv =====
// modem power sequencer: request register, phase step and response register
// a request taken into the input register is stepped and presented from the response register
// throughput: one request per cycle while the response is not stalled; the phase step sits between two registers
// a stalled response holds while one further request waits in the input register
// reset (synchronous, active high): idle phase, timer zero, key and relay off,
// all timing registers back to 3000 ticks
`default_nettype none
module modem_power_sequencer_top #(
   parameter int TIMER_WIDTH = mps_pkg::TIMER_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic [mps_pkg::CMD_WIDTH-1:0]        req_command,
   input  wire logic                                 req_ms_tick,
   input  wire logic                                 req_power_status,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic                                 rsp_power_key,
   output      logic                                 rsp_relay_energised,
   output      logic                                 rsp_complete,
   output      logic                                 rsp_accepted,
   output      logic [mps_pkg::BEEP_WIDTH-1:0]       rsp_beep_pulses,
   output      logic [mps_pkg::PHASE_WIDTH-1:0]      rsp_phase,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [mps_pkg::CFG_WIDTH-1:0]        csr_write_data
);
   import mps_pkg::*;

   cfg_type              cfg;
   result_type           result;
   result_type           rsp_data_ff;
   logic                 rsp_valid_ff;
   logic                 in_valid_ff;
   logic [CMD_WIDTH-1:0] in_command_ff;
   logic                 in_tick_ff;
   logic                 in_status_ff;
   logic                 advance;

   // step the held request when the response slot is free or being taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_command_ff <= req_command;
         in_tick_ff    <= req_ms_tick;
         in_status_ff  <= req_power_status;
      end
   end

   mps_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mps_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .command      (in_command_ff),
      .ms_tick      (in_tick_ff),
      .power_status (in_status_ff),
      .cfg          (cfg),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_power_key       = rsp_data_ff.power_key;
   assign rsp_relay_energised = rsp_data_ff.relay_energised;
   assign rsp_complete        = rsp_data_ff.complete;
   assign rsp_accepted        = rsp_data_ff.accepted;
   assign rsp_beep_pulses     = rsp_data_ff.beep_pulses;
   assign rsp_phase           = rsp_data_ff.phase;

endmodule
`default_nettype wire

// ===== hdl/mps_csr.sv =====
// timing registers written through the csr port
`default_nettype none
module mps_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [mps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [mps_pkg::CFG_WIDTH-1:0]       csr_write_data,
   output mps_pkg::cfg_type                         cfg
);
   import mps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_KEY_PULSE:  cfg_in.key_pulse_ticks  = csr_write_data;
            REG_SETTLE:     cfg_in.settle_ticks     = csr_write_data;
            REG_RELAY_HOLD: cfg_in.relay_hold_ticks = csr_write_data;
            REG_COOLDOWN:   cfg_in.cooldown_ticks   = csr_write_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_pulse_ticks  <= DEFAULT_TICKS;
         cfg_ff.settle_ticks     <= DEFAULT_TICKS;
         cfg_ff.relay_hold_ticks <= DEFAULT_TICKS;
         cfg_ff.cooldown_ticks   <= DEFAULT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hdl/mps_core.sv =====
// sequencer state and the per-request phase step
`default_nettype none
module mps_core #(
   parameter int TIMER_WIDTH = mps_pkg::TIMER_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step_en,
   input  wire logic [mps_pkg::CMD_WIDTH-1:0] command,
   input  wire logic                          ms_tick,
   input  wire logic                          power_status,
   input  wire mps_pkg::cfg_type              cfg,
   output mps_pkg::result_type                result
);
   import mps_pkg::*;

   localparam int CmpWidth = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

   phase_type              phase_ff, phase_in, phase_cur;
   logic [TIMER_WIDTH-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic                   key_ff, key_in;
   logic                   relay_ff, relay_in;
   logic                   accepted;
   logic [BEEP_WIDTH-1:0]  beep;
   logic [CFG_WIDTH-1:0]   limit;
   logic                   waited;

   // command is handled before the timer and the phase step
   always_comb begin
      phase_cur = phase_ff;
      accepted  = 1'b0;
      if (command == CMD_RESTART && phase_ff == PH_IDLE) begin
         phase_cur = PH_OFF;
         accepted  = 1'b1;
      end else if (command == CMD_RELEASE && phase_ff == PH_DONE) begin
         phase_cur = PH_IDLE;
         accepted  = 1'b1;
      end
   end

   // saturating millisecond count
   assign elapsed_inc = (ms_tick && elapsed_ff != {TIMER_WIDTH{1'b1}})
                        ? elapsed_ff + TIMER_WIDTH'(1) : elapsed_ff;

   always_comb begin
      unique case (phase_cur)
         PH_OFF_SETTLE, PH_ON_SETTLE: limit = cfg.settle_ticks;
         PH_HARD_HOLD:                limit = cfg.relay_hold_ticks;
         PH_COOLDOWN:                 limit = cfg.cooldown_ticks;
         default:                     limit = cfg.key_pulse_ticks;
      endcase
   end

   assign waited = CmpWidth'(elapsed_inc) > CmpWidth'(limit);

   always_comb begin
      phase_in   = phase_cur;
      elapsed_in = elapsed_inc;
      key_in     = key_ff;
      relay_in   = relay_ff;
      beep       = BEEP_NONE;
      unique case (phase_cur)
         PH_OFF: begin
            beep = BEEP_START;
            if (power_status) begin
               key_in     = 1'b1;
               elapsed_in = '0;
               phase_in   = PH_OFF_HOLD;
            end else begin
               phase_in = PH_ON;
            end
         end
         PH_OFF_HOLD, PH_ON_HOLD: begin
            if (waited) begin
               key_in     = 1'b0;
               elapsed_in = '0;
               phase_in   = (phase_cur == PH_OFF_HOLD) ? PH_OFF_SETTLE : PH_ON_SETTLE;
            end
         end
         PH_OFF_SETTLE: begin
            if (waited) begin
               if (power_status) begin
                  beep     = BEEP_OFF_FAIL;
                  phase_in = PH_HARD;
               end else begin
                  phase_in = PH_ON;
               end
            end
         end
         PH_ON: begin
            key_in     = 1'b1;
            elapsed_in = '0;
            phase_in   = PH_ON_HOLD;
         end
         PH_ON_SETTLE: begin
            if (waited) begin
               if (!power_status) begin
                  beep     = BEEP_ON_FAIL;
                  phase_in = PH_HARD;
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
         PH_HARD: begin
            relay_in   = 1'b1;
            elapsed_in = '0;
            phase_in   = PH_HARD_HOLD;
         end
         PH_HARD_HOLD: begin
            if (waited) begin
               relay_in   = 1'b0;
               elapsed_in = '0;
               phase_in   = PH_COOLDOWN;
            end
         end
         PH_COOLDOWN: begin
            if (waited) begin
               phase_in = PH_OFF;
            end
         end
         PH_IDLE, PH_DONE: begin
            phase_in = phase_cur;
         end
         default: begin
            phase_in = phase_cur;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         key_ff     <= 1'b0;
         relay_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         key_ff     <= key_in;
         relay_ff   <= relay_in;
      end
   end

   assign result.power_key       = key_in;
   assign result.relay_energised = relay_in;
   assign result.complete        = (phase_in == PH_DONE);
   assign result.accepted        = accepted;
   assign result.beep_pulses     = beep;
   assign result.phase           = phase_number(phase_in);

   // key and relay are never driven together
   a_key_relay_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(key_ff && relay_ff))
      else $error("power key and relay both active");

   // relay only energised while holding in hard reset
   a_relay_phase: assert property (@(posedge clock) disable iff (reset)
      relay_ff |-> (phase_ff == PH_HARD_HOLD))
      else $error("relay energised outside hold phase");

   // key only held during a key pulse
   a_key_phase: assert property (@(posedge clock) disable iff (reset)
      key_ff |-> (phase_ff == PH_OFF_HOLD || phase_ff == PH_ON_HOLD))
      else $error("power key held outside pulse phase");

   // a restart from idle always leaves idle on the same step
   a_restart_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && phase_ff == PH_IDLE && command == CMD_RESTART)
      |=> (phase_ff != PH_IDLE && phase_ff != PH_OFF))
      else $error("restart did not start the sequence");

endmodule
`default_nettype wire
